/* hw/rtl/adgr_pkg.sv */
// ----------------------------------------------------------------------------
// adgr_pkg: shared types and constants for the ducking gain ramp
// Controller states, command and status bundles, and the gain table function.
// ----------------------------------------------------------------------------
package adgr_pkg;

	localparam int unsigned MAX_ATTEN_DB_DEF = 51;
	localparam int unsigned SAMPLE_W = 32;
	localparam int unsigned LEN_W = 32;
	localparam int unsigned DIV_CNT_W = $clog2(LEN_W);
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned SB_W = 3;
	localparam logic [SB_W-1:0] SAMPLE_BYTES_RST = 3'd2;

	// Register index, taken from the word address bit of paddr.
	localparam logic REG_SAMPLE_BYTES = 1'b0;

	// Per-dB Q32 attenuation factor and unity gain in Q31.
	localparam logic [63:0] STEP_FACTOR = 64'd3827893632;
	localparam logic [63:0] UNITY_Q31 = 64'h7FFF_FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_WRITE,
		ST_DIV,
		ST_DIV_END
	} adgr_state_t;

	typedef struct packed {
		logic accept_sample;
		logic accept_target;
		logic mul_en;
		logic out_load;
		logic div_step;
		logic div_commit;
	} adgr_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_free;
	} adgr_sts_t;

	// Q31 gain for a level in dB, built by repeated Q32 multiplication.
	// Only evaluated at elaboration to fill the gain table.
	function automatic logic [31:0] adgr_gain(input int lvl, input int max_db);
		logic [63:0] f;
		int n;
		f = UNITY_Q31;
		n = (lvl > max_db) ? max_db : lvl;
		for (int i = 0; i < 128; i++) begin
			if (i < n) begin
				f = (f * STEP_FACTOR) >> 32;
			end
		end
		return f[31:0];
	endfunction

endpackage

/* hw/rtl/adgr_ctrl.sv */
// ----------------------------------------------------------------------------
// adgr_ctrl: sequencing controller for the ducking gain ramp
// Steps samples through gain lookup, multiply and output load, and runs the
// bit-serial divider for ramp set-up.
// ----------------------------------------------------------------------------
module adgr_ctrl
	import adgr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      op,
	input  adgr_sts_t sts,
	output logic      in_stall,
	output adgr_cmd_t cmd
);

	adgr_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!op) begin
						state_nxt = ST_MUL;
					end else if (sts.need_div) begin
						state_nxt = ST_DIV;
					end
				end
			end
			ST_MUL: begin
				state_nxt = ST_WRITE;
			end
			ST_WRITE: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_nxt = ST_DIV_END;
				end
			end
			ST_DIV_END: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.accept_sample = in_valid && !op;
				cmd.accept_target = in_valid && op;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
			end
			ST_WRITE: begin
				cmd.out_load = sts.out_free;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_DIV_END: begin
				cmd.div_commit = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

/* hw/rtl/adgr_datapath.sv */
// ----------------------------------------------------------------------------
// adgr_datapath: level state, gain table, multiplier and divider
// Holds the ramp state, scales samples and computes the step period.
// ----------------------------------------------------------------------------
module adgr_datapath
	import adgr_pkg::*;
#(
	parameter int unsigned MAX_ATTEN_DB = MAX_ATTEN_DB_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  adgr_cmd_t                  cmd,
	output adgr_sts_t                  sts,
	input  logic [SB_W-1:0]            sample_bytes,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic [7:0]                 target_db,
	input  logic [LEN_W-1:0]           transition_length,
	input  logic                       out_stall,
	output logic                       out_valid,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic [6:0]                 level_db,
	output logic                       ramping
);

	localparam int unsigned LVL_W = $clog2(MAX_ATTEN_DB + 1);
	localparam int unsigned ROM_D = 2 ** LVL_W;

	// Ramp state.
	logic [LVL_W-1:0] target_q;
	logic [LVL_W-1:0] level_q;
	logic             step_down_q;
	logic [LEN_W-1:0] period_q;
	logic [LEN_W-1:0] left_q;
	logic [LEN_W-1:0] cnt_q;

	// Divider.
	logic [LEN_W-1:0]     quo_q;
	logic [LVL_W-1:0]     rem_q;
	logic [LVL_W-1:0]     divisor_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [LVL_W:0]       trial;
	logic [LVL_W:0]       trial_sub;
	logic                 trial_ge;

	// Sample path.
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [31:0]                gain_s1;
	logic [LVL_W-1:0]           lvl_s1;
	logic                       bypass_s1;
	logic                       ramp_s1;
	logic signed [63:0]         prod_s2;
	logic signed [SAMPLE_W-1:0] sample_ext;
	logic                       out_valid_q;

	logic [LVL_W-1:0] t_clamp;
	logic [LVL_W-1:0] lvl_gap;
	logic [LVL_W-1:0] steps;
	logic             same;
	logic             up;
	logic [LVL_W-1:0] level_step;

	logic [31:0] gain_rom [ROM_D];

	for (genvar g = 0; g < ROM_D; g++) begin : g_rom
		assign gain_rom[g] = adgr_gain(g, int'(MAX_ATTEN_DB));
	end

	// Target decode.
	assign t_clamp = (target_db > 8'(MAX_ATTEN_DB)) ? LVL_W'(MAX_ATTEN_DB)
		: target_db[LVL_W-1:0];
	assign same = (t_clamp == target_q);
	assign up = (t_clamp > target_q);
	assign lvl_gap = up ? (t_clamp - target_q) : (target_q - t_clamp);
	assign steps = lvl_gap - LVL_W'(1);
	assign level_step = step_down_q ? (level_q - LVL_W'(1)) : (level_q + LVL_W'(1));

	assign trial = {rem_q, quo_q[LEN_W-1]};
	assign trial_ge = (trial >= {1'b0, divisor_q});
	assign trial_sub = trial - {1'b0, divisor_q};

	always_comb begin
		case (sample_bytes)
			3'd0, 3'd1: sample_ext = SAMPLE_W'($signed(sample_in[7:0]));
			3'd2: sample_ext = SAMPLE_W'($signed(sample_in[15:0]));
			3'd3: sample_ext = SAMPLE_W'($signed(sample_in[23:0]));
			default: sample_ext = sample_in;
		endcase
	end

	assign sts.need_div = !same && (steps != '0) && (transition_length >= LEN_W'(steps));
	assign sts.div_last = (div_cnt_q == '1);
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			level_q <= '0;
			step_down_q <= 1'b0;
			period_q <= '0;
			left_q <= '0;
			cnt_q <= '0;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept_target && !same) begin
				target_q <= t_clamp;
				step_down_q <= !up;
				div_cnt_q <= '0;
				if (sts.need_div) begin
					// First step is taken at once; the length rides in left_q
					// until the remainder is known.
					level_q <= up ? (target_q + LVL_W'(1)) : (target_q - LVL_W'(1));
					left_q <= transition_length;
				end else begin
					level_q <= t_clamp;
					left_q <= '0;
				end
			end else if (cmd.accept_sample && (left_q != '0)) begin
				if (cnt_q == LEN_W'(1)) begin
					level_q <= level_step;
					cnt_q <= period_q;
				end else begin
					cnt_q <= cnt_q - LEN_W'(1);
				end
				left_q <= left_q - LEN_W'(1);
			end else if (cmd.div_commit) begin
				period_q <= quo_q;
				cnt_q <= quo_q;
				left_q <= left_q - LEN_W'(rem_q);
			end
			if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_target) begin
			quo_q <= transition_length;
			rem_q <= '0;
			divisor_q <= steps;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_sub[LVL_W-1:0] : trial[LVL_W-1:0];
			quo_q <= {quo_q[LEN_W-2:0], trial_ge};
		end
		if (cmd.accept_sample) begin
			sample_s1 <= sample_ext;
			gain_s1 <= gain_rom[level_q];
			lvl_s1 <= level_q;
			bypass_s1 <= (left_q == '0) && (level_q == '0);
			ramp_s1 <= (left_q > LEN_W'(1));
		end
		if (cmd.mul_en) begin
			prod_s2 <= sample_s1 * $signed({1'b0, gain_s1[30:0]});
		end
		if (cmd.out_load) begin
			sample_out <= bypass_s1 ? sample_s1 : prod_s2[62:31];
			level_db <= 7'(lvl_s1);
			ramping <= ramp_s1;
		end
	end

	assign out_valid = out_valid_q;

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LVL_W'(MAX_ATTEN_DB))
		else $error("level left the attenuation range");

	a_settled_at_target: assert property (@(posedge clk) disable iff (!arst_n)
		(left_q == '0) |-> (level_q == target_q))
		else $error("ramp ended away from its target");

	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= period_q)
		else $error("step counter exceeds step period");

endmodule

/* hw/rtl/audio_ducking_gain_ramp.sv */
// ----------------------------------------------------------------------------
// audio_ducking_gain_ramp: dB-step ducking gain with timed ramps
// Scales audio samples by a whole-dB gain and ramps to new targets.
// ----------------------------------------------------------------------------
// An op 0 item carries one audio sample, sign-extended from sample_bytes bytes,
// and yields one result item: the sample scaled by the Q31 gain of the current
// level (floor of product over 2^31), the level applied, and whether a ramp is
// still running afterwards. When the block is settled at 0 dB the sample passes
// through unchanged. An op 1 item sets a new target, clamped to MAX_ATTEN_DB,
// and yields no result. A ramp starts from the old target with its first 1 dB
// step taken at once; the remaining steps are spread over transition_length
// samples, with the step period being transition_length divided by the number
// of remaining steps. If that quotient is zero, or no steps remain, the level
// jumps straight to the target. A sample item occupies the block through accept
// with gain table read, multiply and output register load, longer only while
// the output register still holds an untaken item. A target item whose level
// jumps occupies only its accept state; one that needs a step period then runs
// the bit-serial divider, which retires one quotient bit per cycle over the
// 32-bit length, and its commit state. The next item is accepted while a
// finished result still waits in the output register.
module audio_ducking_gain_ramp
	import adgr_pkg::*;
#(
	parameter int unsigned MAX_ATTEN_DB = MAX_ATTEN_DB_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [PADDR_W-1:0]         paddr,
	input  logic [PDATA_W-1:0]         pwdata,
	output logic [PDATA_W-1:0]         prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic [7:0]                 target_db,
	input  logic [LEN_W-1:0]           transition_length,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic [6:0]                 level_db,
	output logic                       ramping
);

	adgr_cmd_t       cmd;
	adgr_sts_t       sts;
	logic [SB_W-1:0] sample_bytes_q;
	logic            reg_hit;

	// The register sits at word 0; the low address bits select a byte and are
	// ignored. Writes to any other word are dropped.
	assign pready = 1'b1;
	assign reg_hit = (paddr[2] == REG_SAMPLE_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_bytes_q <= SAMPLE_BYTES_RST;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			sample_bytes_q <= pwdata[SB_W-1:0];
		end
	end

	assign prdata = reg_hit ? PDATA_W'(sample_bytes_q) : '0;

	adgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	adgr_datapath #(
		.MAX_ATTEN_DB (MAX_ATTEN_DB)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.sample_bytes      (sample_bytes_q),
		.sample_in         (sample_in),
		.target_db         (target_db),
		.transition_length (transition_length),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.sample_out        (sample_out),
		.level_db          (level_db),
		.ramping           (ramping)
	);

endmodule
